// ===== sv/bcc_pkg.sv =====
package bcc_pkg;

    // argument and result sizing
    localparam int ARG_WIDTH    = 16;
    localparam int RESULT_WIDTH = 64;
    localparam int PROD_W       = 64;                 // running product register
    localparam int HALF_W       = PROD_W / 2;         // multiplier split point
    localparam int OPD_W        = ARG_WIDTH + 1;      // 2n, n-i, i+1, n+1
    localparam int LO_W         = HALF_W + OPD_W;     // partial product width
    localparam int CNT_W        = $clog2(PROD_W);     // divider bit counter

    localparam logic [PROD_W-1:0] RES_MASK = {PROD_W{1'b1}} >> (PROD_W - RESULT_WIDTH);

    // datapath commands
    typedef logic [2:0] dp_op_t;
    localparam dp_op_t OP_NONE       = 3'd0;
    localparam dp_op_t OP_LOAD       = 3'd1;
    localparam dp_op_t OP_MUL_LO     = 3'd2;
    localparam dp_op_t OP_MUL_HI     = 3'd3;
    localparam dp_op_t OP_DIV_STEP   = 3'd4;
    localparam dp_op_t OP_COMMIT     = 3'd5;
    localparam dp_op_t OP_FINAL_LOAD = 3'd6;
    localparam dp_op_t OP_OUT        = 3'd7;

    typedef struct packed {
        logic steps_done;   // i == k
        logic catalan;      // current word is a Catalan request
        logic div_last;     // divider on its last bit
    } dp_status_t;

endpackage

// ===== sv/bcc_datapath.sv =====
module bcc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bcc_pkg::dp_op_t                   op,
    input  logic                              kind,
    input  logic [bcc_pkg::ARG_WIDTH-1:0]     n_value,
    input  logic [bcc_pkg::ARG_WIDTH-1:0]     k_value,
    output bcc_pkg::dp_status_t               sts,
    output logic [63:0]                       result
);

    logic [bcc_pkg::OPD_W-1:0]  n_reg, n_next;
    logic [bcc_pkg::OPD_W-1:0]  k_reg, k_next;
    logic [bcc_pkg::OPD_W-1:0]  i_reg, i_next;
    logic                       cat_reg, cat_next;
    logic [bcc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bcc_pkg::LO_W-1:0]   lo_reg, lo_next;
    logic [bcc_pkg::PROD_W-1:0] q_reg, q_next;
    logic [bcc_pkg::OPD_W-1:0]  rem_reg, rem_next;
    logic [bcc_pkg::OPD_W-1:0]  dvs_reg, dvs_next;
    logic [bcc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bcc_pkg::PROD_W-1:0] res_reg, res_next;

    logic [bcc_pkg::OPD_W-1:0]  n_ext, k_ext, n_dbl, n_diff;
    logic [bcc_pkg::OPD_W-1:0]  mfac;
    logic [bcc_pkg::LO_W-1:0]   lo_prod, hi_prod;
    logic [bcc_pkg::PROD_W-1:0] mul_sum;
    logic [bcc_pkg::OPD_W:0]    trial, trial_sub;
    logic                       trial_ge;

    assign n_ext  = {1'b0, n_value};
    assign k_ext  = {1'b0, k_value};
    assign n_dbl  = {n_value, 1'b0};
    assign n_diff = n_ext - k_ext;

    // factor n - i, product split in two 32-bit halves, low half multiplied first
    assign mfac    = n_reg - i_reg;
    assign lo_prod = prod_reg[bcc_pkg::HALF_W-1:0] * mfac;
    assign hi_prod = prod_reg[bcc_pkg::PROD_W-1:bcc_pkg::HALF_W] * mfac;
    assign mul_sum = bcc_pkg::PROD_W'(lo_reg)
                   + {hi_prod[bcc_pkg::HALF_W-1:0], {bcc_pkg::HALF_W{1'b0}}};

    // restoring divider, one quotient bit per cycle
    assign trial     = {rem_reg, q_reg[bcc_pkg::PROD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        n_next    = n_reg;
        k_next    = k_reg;
        i_next    = i_reg;
        cat_next  = cat_reg;
        prod_next = prod_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        unique case (op)
            bcc_pkg::OP_LOAD:
            begin
                i_next = '0;
                if (kind)
                begin
                    // C(2n, n): never swapped
                    cat_next  = 1'b1;
                    n_next    = n_dbl;
                    k_next    = n_ext;
                    prod_next = bcc_pkg::PROD_W'(1);
                end
                else
                begin
                    cat_next = 1'b0;
                    n_next   = n_ext;
                    if (k_ext > n_ext)
                    begin
                        k_next    = '0;
                        prod_next = '0;
                    end
                    else
                    begin
                        k_next    = (k_ext > n_diff) ? n_diff : k_ext;
                        prod_next = bcc_pkg::PROD_W'(1);
                    end
                end
            end
            bcc_pkg::OP_MUL_LO:
            begin
                lo_next = lo_prod;
            end
            bcc_pkg::OP_MUL_HI:
            begin
                q_next   = mul_sum & bcc_pkg::RES_MASK;
                rem_next = '0;
                dvs_next = i_reg + bcc_pkg::OPD_W'(1);
                cnt_next = '0;
            end
            bcc_pkg::OP_DIV_STEP:
            begin
                rem_next = trial_ge ? trial_sub[bcc_pkg::OPD_W-1:0]
                                    : trial[bcc_pkg::OPD_W-1:0];
                q_next   = {q_reg[bcc_pkg::PROD_W-2:0], trial_ge};
                cnt_next = cnt_reg + bcc_pkg::CNT_W'(1);
            end
            bcc_pkg::OP_COMMIT:
            begin
                prod_next = q_reg;
                i_next    = i_reg + bcc_pkg::OPD_W'(1);
            end
            bcc_pkg::OP_FINAL_LOAD:
            begin
                // Catalan: divide by n + 1 (k holds n)
                q_next   = prod_reg;
                rem_next = '0;
                dvs_next = k_reg + bcc_pkg::OPD_W'(1);
                cnt_next = '0;
            end
            bcc_pkg::OP_OUT:
            begin
                res_next = prod_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            i_reg   <= '0;
            cat_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            i_reg   <= i_next;
            cat_reg <= cat_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        prod_reg <= prod_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        res_reg  <= res_next;
    end

    assign sts.steps_done = (i_reg == k_reg);
    assign sts.catalan    = cat_reg;
    assign sts.div_last   = (cnt_reg == bcc_pkg::CNT_W'(bcc_pkg::PROD_W - 1));
    assign result         = 64'(res_reg);

endmodule

// ===== sv/bcc_controller.sv =====
module bcc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bcc_pkg::dp_status_t sts,
    output bcc_pkg::dp_op_t     op
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MUL_LO = 3'd2;
    localparam logic [2:0] S_MUL_HI = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       final_reg, final_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        op         = bcc_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = bcc_pkg::OP_LOAD;
                    final_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (!sts.steps_done)
                begin
                    state_next = S_MUL_LO;
                end
                else if (sts.catalan && !final_reg)
                begin
                    op         = bcc_pkg::OP_FINAL_LOAD;
                    final_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MUL_LO:
            begin
                op         = bcc_pkg::OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                op         = bcc_pkg::OP_MUL_HI;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op = bcc_pkg::OP_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                op         = bcc_pkg::OP_COMMIT;
                state_next = final_reg ? S_OUT : S_CHECK;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!ov_reg || !out_stall)
                begin
                    op         = bcc_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        priority if (op == bcc_pkg::OP_OUT)
        begin
            ov_next = 1'b1;
        end
        else if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

endmodule

// ===== sv/binomial_catalan_calculator_core.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   kind, n_value[15:0], k_value[15:0]
// out      output     out_valid / out_stall result[63:0]
//
// A word runs min(k, n-k) multiply-divide steps for C(n,k), plus a final
//   divide by n+1 on a Catalan word (k = n over 2n). Each step is two
//   32-bit partial multiplies, a restoring divide by i+1, and a
//   commit/check pair. The next word can be taken once the result is registered.
// Most of the time goes to the divider (one quotient bit per cycle).
// Reset: asynchronous, active low; the block comes up idle with no result.
// A result waiting on out_stall sits in the output register; the next word
//   is taken once the datapath is idle, so in and out overlap by one word.
module binomial_catalan_calculator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [bcc_pkg::ARG_WIDTH-1:0] n_value,
    input  logic [bcc_pkg::ARG_WIDTH-1:0] k_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   result
);

    bcc_pkg::dp_op_t     op;
    bcc_pkg::dp_status_t sts;

    // sequencer: decides the step order, owns the handshakes
    bcc_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .op        (op)
    );

    // running product, split multiplier, serial divider, output register
    bcc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .kind    (kind),
        .n_value (n_value),
        .k_value (k_value),
        .sts     (sts),
        .result  (result)
    );

`ifndef NO_ASSERTIONS
    // a fresh result only appears after a busy cycle
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without work in progress");

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accepting a word");

    // C(n,0) needs no multiply-divide steps
    a_k_zero_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !kind && k_value == '0) |=> sts.steps_done)
        else $error("step count not zero for k of zero");
`endif

endmodule
